/* design/prfd_pkg.sv */
// ----------------------------------------------------------------------------
// PLL frequency decode package
// Widths, status codes, pipeline geometry and the divider step function
// shared by the decode core, its channel interfaces and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package prfd_pkg;

   localparam int REF_W    = 10;
   localparam int STAT_W   = 16;
   localparam int FB_W     = 27;
   localparam int OUT_W    = 19;
   localparam int FREQ_W   = 16;
   localparam int STATUS_W = 2;

   localparam int DIV_FIELD_W  = 8;
   localparam int FRAC_W       = 10;
   localparam int FAC_W        = 18;
   localparam int NUM_W        = REF_W + FAC_W;
   localparam int DEN_W        = DIV_FIELD_W + FAC_W;
   localparam int QUO_W        = FREQ_W;
   localparam int NUM_HI_W     = NUM_W - QUO_W;

   localparam int FB_DIV_LSB   = 0;
   localparam int FB_MUL_LSB   = 8;
   localparam int FB_FRAC_LSB  = 16;
   localparam int FB_FRAC_EN   = 26;
   localparam int OW_DIV_LSB   = 0;
   localparam int OW_FRAC_LSB  = 8;
   localparam int OW_FRAC_EN   = 18;

   localparam logic [FAC_W-1:0]    THOUSAND   = FAC_W'(1000);
   localparam logic [REF_W-1:0]    REF_RESET  = REF_W'(100);
   localparam logic [FREQ_W-1:0]   FREQ_MAX   = '1;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BUSY     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ZERO_DIV = 2'd2;

   localparam int STEP_BITS  = 2;
   localparam int DIV_STAGES = QUO_W / STEP_BITS;
   localparam int INIT_STAGE = 2;
   localparam int LAST_STAGE = INIT_STAGE + DIV_STAGES;
   localparam int N_STAGES   = LAST_STAGE + 1;

   typedef struct packed {
      logic [DEN_W-1:0] rem;
      logic [QUO_W-1:0] qn;
   } div_step_type;

   // Restoring division: the low numerator bits shift out of qn while the
   // quotient bits shift in behind them.
   function automatic div_step_type div_steps(input logic [DEN_W-1:0] rem_i,
                                              input logic [QUO_W-1:0] qn_i,
                                              input logic [DEN_W-1:0] den_i);
      logic [DEN_W:0]   trial;
      logic             ge;
      div_step_type     res;
      res.rem = rem_i;
      res.qn  = qn_i;
      for (int i = 0; i < STEP_BITS; i++) begin
         trial = {res.rem, res.qn[QUO_W-1]};
         ge    = (trial >= {1'b0, den_i});
         if (ge) begin
            trial = trial - {1'b0, den_i};
         end
         res.rem = trial[DEN_W-1:0];
         res.qn  = {res.qn[QUO_W-2:0], ge};
      end
      return res;
   endfunction

endpackage

`default_nettype wire

/* design/prfd_if.sv */
// ----------------------------------------------------------------------------
// PLL frequency decode channels
// Valid/ready channels for register snapshots in and frequency results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface prfd_req_if import prfd_pkg::*;;
   logic              valid;
   logic              ready;
   logic [STAT_W-1:0] status_word;
   logic [FB_W-1:0]   feedback_word;
   logic [OUT_W-1:0]  output_word;

   modport source (output valid, output status_word, output feedback_word,
                   output output_word, input ready);
   modport sink (input valid, input status_word, input feedback_word,
                 input output_word, output ready);
   modport monitor (input valid, input ready, input status_word,
                    input feedback_word, input output_word);
endinterface

interface prfd_rsp_if import prfd_pkg::*;;
   logic                valid;
   logic                ready;
   logic [FREQ_W-1:0]   freq_mhz;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output freq_mhz, output status, input ready);
   modport sink (input valid, input freq_mhz, input status, output ready);
   modport monitor (input valid, input ready, input freq_mhz, input status);
endinterface

`default_nettype wire

/* design/pll_register_frequency_decode_core.sv */
// ----------------------------------------------------------------------------
// PLL register frequency decode core
// Throughput: one transfer per cycle when the result side does not stall,
// set by the 11-stage pipeline whose last 8 stages each resolve two quotient
// bits of the divider; a stalled result holds back the full stages behind it.
// Reset clears all stage valid bits and sets the reference clock to 100 MHz.
// ----------------------------------------------------------------------------
`default_nettype none

module pll_register_frequency_decode_core import prfd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   prfd_req_if.sink         req_ch,
   prfd_rsp_if.source       rsp_ch,
   input  logic             csr_wr_en,
   input  logic [REF_W-1:0] csr_wr_data
);

   logic [REF_W-1:0]    ref_ff;
   logic [N_STAGES-1:0] v_ff;
   logic [N_STAGES-1:0] adv;

   logic                   busy0_ff, busy0_in;
   logic [FAC_W-1:0]       mfac0_ff, mfac0_in;
   logic [FAC_W-1:0]       ofac0_ff, ofac0_in;
   logic [DIV_FIELD_W-1:0] div0_ff;

   logic                   busy1_ff;
   logic [NUM_W-1:0]       num1_ff, num1_in;
   logic [DEN_W-1:0]       den1_ff, den1_in;

   logic [STATUS_W-1:0] st_ff  [INIT_STAGE:LAST_STAGE];
   logic [QUO_W-1:0]    qn_ff  [INIT_STAGE:LAST_STAGE];
   logic                sat_ff [INIT_STAGE:LAST_STAGE-1];
   logic [DEN_W-1:0]    den_ff [INIT_STAGE:LAST_STAGE-1];
   logic [DEN_W-1:0]    rem_ff [INIT_STAGE:LAST_STAGE-1];

   logic [STATUS_W-1:0] st2_in;
   logic                sat2_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff <= REF_RESET;
      end else if (csr_wr_en) begin
         ref_ff <= csr_wr_data;
      end
   end

   assign adv[LAST_STAGE] = !v_ff[LAST_STAGE] || rsp_ch.ready;

   for (genvar k = 0; k < LAST_STAGE; k++) begin : g_adv
      assign adv[k] = !v_ff[k] || adv[k+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (adv[0]) begin
         v_ff[0] <= req_ch.valid;
      end
   end

   for (genvar k = 1; k < N_STAGES; k++) begin : g_valid
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (adv[k]) begin
            v_ff[k] <= v_ff[k-1];
         end
      end
   end

   assign req_ch.ready = adv[0];

   always_comb begin
      logic [FRAC_W-1:0] fm;
      logic [FRAC_W-1:0] fo;
      fm = req_ch.feedback_word[FB_FRAC_EN] ?
           req_ch.feedback_word[FB_FRAC_LSB +: FRAC_W] : '0;
      fo = req_ch.output_word[OW_FRAC_EN] ?
           req_ch.output_word[OW_FRAC_LSB +: FRAC_W] : '0;
      busy0_in = !req_ch.status_word[0];
      mfac0_in = FAC_W'(req_ch.feedback_word[FB_MUL_LSB +: DIV_FIELD_W]) * THOUSAND
                 + FAC_W'(fm);
      ofac0_in = FAC_W'(req_ch.output_word[OW_DIV_LSB +: DIV_FIELD_W]) * THOUSAND
                 + FAC_W'(fo);
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         busy0_ff <= busy0_in;
         mfac0_ff <= mfac0_in;
         ofac0_ff <= ofac0_in;
         div0_ff  <= req_ch.feedback_word[FB_DIV_LSB +: DIV_FIELD_W];
      end
   end

   assign num1_in = NUM_W'(ref_ff) * NUM_W'(mfac0_ff);
   assign den1_in = DEN_W'(div0_ff) * DEN_W'(ofac0_ff);

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         busy1_ff <= busy0_ff;
         num1_ff  <= num1_in;
         den1_ff  <= den1_in;
      end
   end

   always_comb begin
      if (busy1_ff) begin
         st2_in = ST_BUSY;
      end else if (den1_ff == '0) begin
         st2_in = ST_ZERO_DIV;
      end else begin
         st2_in = ST_OK;
      end
      sat2_in = (DEN_W'(num1_ff[NUM_W-1:QUO_W]) >= den1_ff);
   end

   always_ff @(posedge clock) begin
      if (adv[INIT_STAGE]) begin
         st_ff[INIT_STAGE]  <= st2_in;
         sat_ff[INIT_STAGE] <= sat2_in;
         den_ff[INIT_STAGE] <= den1_ff;
         rem_ff[INIT_STAGE] <= DEN_W'(num1_ff[NUM_W-1:QUO_W]);
         qn_ff[INIT_STAGE]  <= num1_ff[QUO_W-1:0];
      end
   end

   for (genvar k = INIT_STAGE + 1; k <= LAST_STAGE; k++) begin : g_div
      div_step_type step;

      assign step = div_steps(rem_ff[k-1], qn_ff[k-1], den_ff[k-1]);

      if (k < LAST_STAGE) begin : g_mid
         always_ff @(posedge clock) begin
            if (adv[k]) begin
               st_ff[k]  <= st_ff[k-1];
               sat_ff[k] <= sat_ff[k-1];
               den_ff[k] <= den_ff[k-1];
               rem_ff[k] <= step.rem;
               qn_ff[k]  <= step.qn;
            end
         end
      end else begin : g_last
         logic [QUO_W-1:0] freq_in;

         always_comb begin
            if (st_ff[k-1] != ST_OK) begin
               freq_in = '0;
            end else if (sat_ff[k-1]) begin
               freq_in = FREQ_MAX;
            end else begin
               freq_in = step.qn;
            end
         end

         always_ff @(posedge clock) begin
            if (adv[k]) begin
               st_ff[k] <= st_ff[k-1];
               qn_ff[k] <= freq_in;
            end
         end
      end
   end

   assign rsp_ch.valid    = v_ff[LAST_STAGE];
   assign rsp_ch.freq_mhz = qn_ff[LAST_STAGE];
   assign rsp_ch.status   = st_ff[LAST_STAGE];

endmodule

`default_nettype wire

/* design/prfd_checker.sv */
// ----------------------------------------------------------------------------
// PLL frequency decode checker
// Port-level assertions on the decode core, attached by a bind statement.
// ----------------------------------------------------------------------------
`default_nettype none

module prfd_checker import prfd_pkg::*; (
   input logic             clock,
   input logic             reset,
   prfd_req_if.sink        req_ch,
   prfd_rsp_if.source      rsp_ch,
   input logic             csr_wr_en,
   input logic [REF_W-1:0] csr_wr_data
);

   logic unused_inputs;

   assign unused_inputs = req_ch.valid & req_ch.ready & csr_wr_en & (|csr_wr_data);

   a_no_result_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("A result is offered right after reset.");

   a_error_freq_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status != ST_OK) |-> (rsp_ch.freq_mhz == '0))
      else $error("A result with an error status carries a nonzero frequency.");

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ready) |=> rsp_ch.valid)
      else $error("A stalled result was withdrawn.");

   a_payload_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ready) |=>
         ($stable(rsp_ch.freq_mhz) && $stable(rsp_ch.status)))
      else $error("A stalled result changed before its transfer.");

endmodule

bind pll_register_frequency_decode_core prfd_checker u_prfd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ch      (req_ch),
   .rsp_ch      (rsp_ch),
   .csr_wr_en   (csr_wr_en),
   .csr_wr_data (csr_wr_data)
);

`default_nettype wire
